/* hw/rtl/h264_rtp_fua_packetizer_top_assert.svh */
// ----------------------------------------------------------------------------
// h264_rtp_fua_packetizer_top_assert
// Assertion macros shared by the packetizer RTL.
// ----------------------------------------------------------------------------
// Each use needs clk and rst_n in scope.
`ifndef H264_RTP_FUA_PACKETIZER_TOP_ASSERT_SVH
`define H264_RTP_FUA_PACKETIZER_TOP_ASSERT_SVH

// Check that a condition holds at every clock edge outside reset.
`define FUA_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Check that a consequent holds in the same cycle as its antecedent.
`define FUA_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/h264fua_pkg.sv */
// ----------------------------------------------------------------------------
// h264fua_pkg
// Shared types and constants of the H.264 RTP / FU-A packetizer.
// ----------------------------------------------------------------------------
package h264fua_pkg;

    // Register indexes of the configuration port
    localparam logic [1:0] REG_SSRC_ID      = 2'd0;
    localparam logic [1:0] REG_PAYLOAD_TYPE = 2'd1;
    localparam logic [1:0] REG_MAX_PAYLOAD  = 2'd2;

    localparam logic [31:0] SSRC_RESET     = 32'h5566_7788;
    localparam logic [6:0]  PT_RESET       = 7'd96;
    localparam logic [10:0] MAXPAY_RESET   = 11'd1280;
    localparam logic [10:0] MAXPAY_FLOOR   = 11'd16;

    localparam logic [7:0]  RTP_VERSION_BYTE = 8'h80;
    localparam logic [7:0]  NRI_MASK         = 8'hE0;
    localparam logic [7:0]  TYPE_MASK        = 8'h1F;
    localparam logic [7:0]  FU_A_TYPE        = 8'd28;
    localparam logic [7:0]  FU_START_BIT     = 8'h80;
    localparam logic [7:0]  FU_END_BIT       = 8'h40;
    localparam logic [7:0]  FU_MIDDLE        = 8'h00;

    // Header work that goes ahead of a payload byte
    typedef enum logic [1:0] {
        KIND_DATA = 2'd0,   // payload byte only
        KIND_RTP  = 2'd1,   // 12-byte RTP header, then payload byte
        KIND_FU   = 2'd2    // RTP header, FU indicator, FU header, then byte
    } kind_t;

    localparam logic [3:0] RTP_HDR_LEN = 4'd12;
    localparam logic [3:0] FU_HDR_LEN  = 4'd14;

    typedef struct packed {
        logic [7:0]  nalu_byte;
        logic [23:0] nalu_length;
        logic [31:0] time_stamp;
    } nalu_beat_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       packet_start;
        logic       packet_end;
        logic       run_last;
    } rtp_beat_t;

    // One classified NALU byte, as handed from front end to back end
    typedef struct packed {
        kind_t       kind;
        logic        marker;
        logic [15:0] seq;
        logic [31:0] ts;
        logic [7:0]  fu_ind;
        logic [7:0]  fu_hdr;
        logic [7:0]  data;
        logic        pkt_end;
    } desc_t;

endpackage

/* hw/rtl/h264_rtp_fua_packetizer_top.sv */
// ----------------------------------------------------------------------------
// h264_rtp_fua_packetizer_top
// H.264 NALU to RTP packetizer with FU-A fragmentation.
// ----------------------------------------------------------------------------
// Feed a NAL unit one byte per beat on the nalu channel, header byte first;
// nalu_length and time_stamp count only on the first byte of each NALU. The
// rtp channel returns packet bytes one per beat: a 12-byte RTP header then
// payload, with packet_start on the first header byte, packet_end on the
// last payload byte, and run_last on the final beat produced by each input
// byte. A NALU that fits max_payload goes out as one packet with the marker
// set; a longer one is split into FU-A fragments (two extra bytes each) and
// its header byte yields no output. Rate: a payload byte that continues a
// packet goes out at one byte per cycle while rtp_ready holds and the
// queue is not empty; a byte that opens a packet first sends the RTP
// header (and for an FU-A fragment the FU indicator and FU header) over
// the single byte-wide output port. A queue of QUEUE_DEPTH descriptors
// lets input keep flowing while a header is being sent out; bytes pass the
// queue and the output register. Write configuration only while the block is idle.
// ----------------------------------------------------------------------------
module h264_rtp_fua_packetizer_top
    import h264fua_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,

    // configuration write port
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,

    // NALU byte stream
    input  logic        nalu_valid,
    output logic        nalu_ready,
    input  nalu_beat_t  nalu_beat,

    // RTP packet byte stream
    output logic        rtp_valid,
    input  logic        rtp_ready,
    output rtp_beat_t   rtp_beat
);

    logic [31:0] ssrc_reg;
    logic [6:0]  pt_reg;
    logic [10:0] maxpay_reg;

    logic        push;
    desc_t       push_desc;
    logic        pop;
    desc_t       head;
    logic        q_full;
    logic        q_empty;

    // Configuration registers: take each write at once, ignore unknown index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ssrc_reg   <= SSRC_RESET;
            pt_reg     <= PT_RESET;
            maxpay_reg <= MAXPAY_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SSRC_ID:      ssrc_reg   <= cfg_data;
                REG_PAYLOAD_TYPE: pt_reg     <= cfg_data[6:0];
                REG_MAX_PAYLOAD:  maxpay_reg <= cfg_data[10:0];
                default:          ;
            endcase
        end
    end

    // Front end: classify each byte and track packet boundaries
    h264fua_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .nalu_valid  (nalu_valid),
        .nalu_ready  (nalu_ready),
        .nalu_beat   (nalu_beat),
        .max_payload (maxpay_reg),
        .q_full      (q_full),
        .push        (push),
        .push_desc   (push_desc)
    );

    // Decouple classification from byte emission
    h264fua_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_desc (push_desc),
        .pop       (pop),
        .head      (head),
        .full      (q_full),
        .empty     (q_empty)
    );

    // Back end: expand headers and drive the output register
    h264fua_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .q_empty      (q_empty),
        .pop          (pop),
        .ssrc_id      (ssrc_reg),
        .payload_type (pt_reg),
        .rtp_valid    (rtp_valid),
        .rtp_ready    (rtp_ready),
        .rtp_beat     (rtp_beat)
    );

endmodule

/* hw/rtl/h264fua_front.sv */
// ----------------------------------------------------------------------------
// h264fua_front
// Accepts NALU bytes, tracks packet and fragment position, and emits one
// descriptor per byte that produces output.
// ----------------------------------------------------------------------------
module h264fua_front
    import h264fua_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        nalu_valid,
    output logic        nalu_ready,
    input  nalu_beat_t  nalu_beat,
    input  logic [10:0] max_payload,
    input  logic        q_full,
    output logic        push,
    output desc_t       push_desc
);

    logic [15:0] seq_reg,      seq_next;
    logic [23:0] pos_reg,      pos_next;
    logic [10:0] fill_reg,     fill_next;
    logic [7:0]  nhdr_reg,     nhdr_next;
    logic [23:0] len_reg,      len_next;
    logic [31:0] ts_reg,       ts_next;
    logic        frag_reg,     frag_next;

    logic        take;
    logic [10:0] mp;
    logic [23:0] len_in;
    logic [24:0] pos_inc;
    logic        last;
    logic [24:0] remain;
    logic [10:0] fill_inc;
    logic        pend;
    logic [7:0]  fu_bits;

    assign nalu_ready = !q_full;
    assign take       = nalu_valid && nalu_ready;
    assign mp         = (max_payload < MAXPAY_FLOOR) ? MAXPAY_FLOOR : max_payload;
    assign len_in     = (nalu_beat.nalu_length == 24'd0) ? 24'd1 : nalu_beat.nalu_length;
    assign pos_inc    = {1'b0, pos_reg} + 25'd1;
    assign last       = pos_inc >= {1'b0, len_reg};
    // bytes still to go in the NALU plus the two FU bytes
    assign remain     = {1'b0, len_reg} - {1'b0, pos_reg} + 25'd2;
    assign fill_inc   = fill_reg + 11'd1;

    always_comb
    begin
        if (pos_reg == 24'd1)
            fu_bits = FU_START_BIT;
        else if (remain <= {14'd0, mp})
            fu_bits = FU_END_BIT;
        else
            fu_bits = FU_MIDDLE;
    end

    always_comb
    begin
        seq_next  = seq_reg;
        pos_next  = pos_reg;
        fill_next = fill_reg;
        nhdr_next = nhdr_reg;
        len_next  = len_reg;
        ts_next   = ts_reg;
        frag_next = frag_reg;
        push      = 1'b0;
        pend      = 1'b0;

        push_desc.kind    = KIND_DATA;
        push_desc.marker  = 1'b0;
        push_desc.seq     = seq_reg;
        push_desc.ts      = ts_reg;
        push_desc.fu_ind  = (nhdr_reg & NRI_MASK) | FU_A_TYPE;
        push_desc.fu_hdr  = fu_bits | (nhdr_reg & TYPE_MASK);
        push_desc.data    = nalu_beat.nalu_byte;
        push_desc.pkt_end = 1'b0;

        if (pos_reg == 24'd0)
        begin
            len_next  = len_in;
            ts_next   = nalu_beat.time_stamp;
            fill_next = 11'd0;
            if (len_in <= {13'd0, mp})
            begin
                // single packet with marker
                frag_next        = 1'b0;
                pend             = (len_in == 24'd1);
                push             = take;
                push_desc.kind   = KIND_RTP;
                push_desc.marker = 1'b1;
                push_desc.ts     = nalu_beat.time_stamp;
                pos_next         = pend ? 24'd0 : 24'd1;
            end
            else
            begin
                // hold the NALU header byte, no output
                frag_next = 1'b1;
                nhdr_next = nalu_beat.nalu_byte;
                pos_next  = 24'd1;
            end
        end
        else
        begin
            push = take;
            if (!frag_reg)
            begin
                pend = last;
            end
            else
            begin
                if (fill_reg == 11'd0)
                    push_desc.kind = KIND_FU;
                pend      = last || (fill_inc >= (mp - 11'd2));
                fill_next = pend ? 11'd0 : fill_inc;
            end
            pos_next = last ? 24'd0 : pos_inc[23:0];
        end

        push_desc.pkt_end = pend;
        if (pend)
            seq_next = seq_reg + 16'd1;
        if (pos_next == 24'd0)
            frag_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg  <= '0;
            pos_reg  <= '0;
            fill_reg <= '0;
            nhdr_reg <= '0;
            len_reg  <= '0;
            ts_reg   <= '0;
            frag_reg <= 1'b0;
        end
        else if (take)
        begin
            seq_reg  <= seq_next;
            pos_reg  <= pos_next;
            fill_reg <= fill_next;
            nhdr_reg <= nhdr_next;
            len_reg  <= len_next;
            ts_reg   <= ts_next;
            frag_reg <= frag_next;
        end
    end

endmodule

/* hw/rtl/h264fua_queue.sv */
// ----------------------------------------------------------------------------
// h264fua_queue
// Small descriptor queue between front end and back end.
// ----------------------------------------------------------------------------
`include "h264_rtp_fua_packetizer_top_assert.svh"

module h264fua_queue
    import h264fua_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  desc_t push_desc,
    input  logic  pop,
    output desc_t head,
    output logic  full,
    output logic  empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    desc_t          slots [DEPTH];
    logic [AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg,  count_next;

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = slots[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slots[wr_ptr_reg] <= push_desc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `FUA_ASSERT_ALWAYS(a_no_overflow, !(push && full), "queue push while full")
    `FUA_ASSERT_ALWAYS(a_no_underflow, !(pop && empty), "queue pop while empty")
    `FUA_ASSERT_IMPLY(a_count_match, (count_reg != '0) && (count_reg != CW'(DEPTH)),
                      wr_ptr_reg != rd_ptr_reg, "queue pointers disagree with count")

endmodule

/* hw/rtl/h264fua_back.sv */
// ----------------------------------------------------------------------------
// h264fua_back
// Expands each descriptor into header bytes and its payload byte through a
// registered output stage, one beat per cycle while not stalled.
// ----------------------------------------------------------------------------
`include "h264_rtp_fua_packetizer_top_assert.svh"

module h264fua_back
    import h264fua_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  desc_t       head,
    input  logic        q_empty,
    output logic        pop,
    input  logic [31:0] ssrc_id,
    input  logic [6:0]  payload_type,
    output logic        rtp_valid,
    input  logic        rtp_ready,
    output rtp_beat_t   rtp_beat
);

    logic [3:0]  step_reg, step_next;
    logic        ov_reg;
    rtp_beat_t   obeat_reg;

    logic [3:0]  hlen;
    logic        is_data;
    logic        advance;
    logic [7:0]  hdr_byte;
    rtp_beat_t   beat;

    always_comb
    begin
        case (head.kind)
            KIND_RTP: hlen = RTP_HDR_LEN;
            KIND_FU:  hlen = FU_HDR_LEN;
            default:  hlen = 4'd0;
        endcase
    end

    assign is_data = (step_reg == hlen);
    assign advance = !q_empty && (!ov_reg || rtp_ready);
    assign pop     = advance && is_data;

    always_comb
    begin
        case (step_reg)
            4'd0:    hdr_byte = RTP_VERSION_BYTE;
            4'd1:    hdr_byte = {head.marker, payload_type};
            4'd2:    hdr_byte = head.seq[15:8];
            4'd3:    hdr_byte = head.seq[7:0];
            4'd4:    hdr_byte = head.ts[31:24];
            4'd5:    hdr_byte = head.ts[23:16];
            4'd6:    hdr_byte = head.ts[15:8];
            4'd7:    hdr_byte = head.ts[7:0];
            4'd8:    hdr_byte = ssrc_id[31:24];
            4'd9:    hdr_byte = ssrc_id[23:16];
            4'd10:   hdr_byte = ssrc_id[15:8];
            4'd11:   hdr_byte = ssrc_id[7:0];
            4'd12:   hdr_byte = head.fu_ind;
            4'd13:   hdr_byte = head.fu_hdr;
            default: hdr_byte = 8'h00;
        endcase
    end

    always_comb
    begin
        beat.out_byte     = is_data ? head.data : hdr_byte;
        beat.packet_start = !is_data && (step_reg == 4'd0);
        beat.packet_end   = is_data && head.pkt_end;
        beat.run_last     = is_data;
        step_next         = is_data ? 4'd0 : step_reg + 4'd1;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            obeat_reg <= beat;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            ov_reg   <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                step_reg <= step_next;
                ov_reg   <= 1'b1;
            end
            else if (rtp_ready)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    assign rtp_valid = ov_reg;
    assign rtp_beat  = obeat_reg;

    `FUA_ASSERT_IMPLY(a_step_bound, !q_empty, step_reg <= hlen,
                      "header step ran past the descriptor's header length")
    `FUA_ASSERT_IMPLY(a_start_not_last, ov_reg && obeat_reg.packet_start,
                      !obeat_reg.run_last && !obeat_reg.packet_end,
                      "packet start beat flagged as last or end")
    `FUA_ASSERT_IMPLY(a_end_is_last, ov_reg && obeat_reg.packet_end, obeat_reg.run_last,
                      "packet end beat not flagged as last")

endmodule

/* sim/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the H.264 RTP / FU-A packetizer.
// ----------------------------------------------------------------------------
// A clocked driver feeds NALU bytes from a pending queue. A bit-accurate
// packetizer model predicts every RTP beat as each byte is accepted. A
// clocked monitor checks each RTP beat, field by field, against the oldest
// prediction. The bench steps through several register settings, including
// the floor and the field maximum of max_payload, and runs one phase with
// no idling on either side.
// ----------------------------------------------------------------------------
module tb;
    import h264fua_pkg::*;

    localparam int STALL_LIMIT   = 2000;   // cycles with no beat on either side
    localparam int SETTLE_CYCLES = 16;     // quiet time before a register write
    localparam int HOLD_AT_BEAT  = 250;    // RTP beat count that arms the hold-off
    localparam int HOLD_MIN_PEND = 20;     // hold-off starts only with more bytes than this still queued
    localparam int HOLD_CYCLES   = 300;

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        cfg_we     = 1'b0;
    logic [1:0]  cfg_index  = REG_SSRC_ID;
    logic [31:0] cfg_data   = '0;
    logic        nalu_valid = 1'b0;
    logic        nalu_ready;
    nalu_beat_t  nalu_beat  = '0;
    logic        rtp_valid;
    logic        rtp_ready  = 1'b0;
    rtp_beat_t   rtp_beat;

    // Stimulus and expectation stores
    nalu_beat_t  nalu_pending [$];
    rtp_beat_t   rtp_expect [$];

    // Packetizer model: register copies
    logic [31:0] ssrc_reg   = SSRC_RESET;
    logic [6:0]  pt_reg     = PT_RESET;
    logic [10:0] maxpay_reg = MAXPAY_RESET;

    // Packetizer model: running state
    logic [15:0] seq_num   = '0;
    logic [23:0] pos       = '0;   // index of the next NALU byte, zero opens a NALU
    logic [10:0] fill      = '0;   // payload bytes in the open fragment
    logic [7:0]  hdr_byte  = '0;   // NALU header held back while fragmenting
    logic [23:0] held_len  = '0;
    logic [31:0] nalu_ts   = '0;
    logic        in_frag   = 1'b0;
    int          run_len;

    // Bench control
    int          errors      = 0;
    int          gen_left    = 0;    // bytes still owed to the NALU the generator opened
    bit          steady      = 1'b0; // no idling on either side while set
    int          beats_seen  = 0;
    int          hold_left   = 0;
    bit          held_off    = 1'b0;
    int          idle_cycles = 0;
    rtp_beat_t   want;

    always #4 clk = ~clk;

    h264_rtp_fua_packetizer_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .nalu_valid (nalu_valid),
        .nalu_ready (nalu_ready),
        .nalu_beat  (nalu_beat),
        .rtp_valid  (rtp_valid),
        .rtp_ready  (rtp_ready),
        .rtp_beat   (rtp_beat)
    );

    // ------------------------------------------------------------------------
    // Packetizer model
    // ------------------------------------------------------------------------

    // Queue one predicted RTP beat; run_last is patched once the run is known.
    function automatic void emit_beat(input logic [7:0] b, input logic s, input logic e);
        rtp_beat_t t;
        t.out_byte     = b;
        t.packet_start = s;
        t.packet_end   = e;
        t.run_last     = 1'b0;
        rtp_expect.push_back(t);
        run_len++;
    endfunction

    // 12-byte RTP header; payload type and SSRC are taken as they stand now.
    function automatic void emit_rtp_header(input logic marker);
        emit_beat(RTP_VERSION_BYTE, 1'b1, 1'b0);
        emit_beat({marker, pt_reg}, 1'b0, 1'b0);
        emit_beat(seq_num[15:8], 1'b0, 1'b0);
        emit_beat(seq_num[7:0], 1'b0, 1'b0);
        emit_beat(nalu_ts[31:24], 1'b0, 1'b0);
        emit_beat(nalu_ts[23:16], 1'b0, 1'b0);
        emit_beat(nalu_ts[15:8], 1'b0, 1'b0);
        emit_beat(nalu_ts[7:0], 1'b0, 1'b0);
        emit_beat(ssrc_reg[31:24], 1'b0, 1'b0);
        emit_beat(ssrc_reg[23:16], 1'b0, 1'b0);
        emit_beat(ssrc_reg[15:8], 1'b0, 1'b0);
        emit_beat(ssrc_reg[7:0], 1'b0, 1'b0);
    endfunction

    // Advance the model by one accepted NALU byte and queue the beats it causes.
    task automatic packetize(input nalu_beat_t nb);
        logic [10:0] mp;
        logic [23:0] len;
        logic [7:0]  fu;
        logic        last;
        logic        frag_end;
        rtp_beat_t   t;
        run_len = 0;
        mp = (maxpay_reg < MAXPAY_FLOOR) ? MAXPAY_FLOOR : maxpay_reg;
        if (pos == 0)
        begin
            // first byte: latch length and timestamp, pick single packet or FU-A
            len      = (nb.nalu_length == 0) ? 24'd1 : nb.nalu_length;
            held_len = len;
            nalu_ts  = nb.time_stamp;
            fill     = '0;
            if (32'(len) <= 32'(mp))
            begin
                in_frag = 1'b0;
                emit_rtp_header(1'b1);
                last = (len == 24'd1);
                emit_beat(nb.nalu_byte, 1'b0, last);
                if (last)
                    seq_num = seq_num + 16'd1;
                pos = last ? 24'd0 : 24'd1;
            end
            else
            begin
                // hold the NALU header back; it only feeds the FU bytes
                in_frag  = 1'b1;
                hdr_byte = nb.nalu_byte;
                pos      = 24'd1;
            end
        end
        else
        begin
            last = (32'(pos) + 1 >= 32'(held_len));
            if (!in_frag)
            begin
                emit_beat(nb.nalu_byte, 1'b0, last);
                if (last)
                    seq_num = seq_num + 16'd1;
            end
            else
            begin
                if (fill == 0)
                begin
                    // S/E bits are fixed when the fragment opens
                    if (pos == 24'd1)
                        fu = FU_START_BIT;
                    else if (32'(held_len) - 32'(pos) + 2 <= 32'(mp))
                        fu = FU_END_BIT;
                    else
                        fu = FU_MIDDLE;
                    emit_rtp_header(1'b0);
                    emit_beat((hdr_byte & NRI_MASK) | FU_A_TYPE, 1'b0, 1'b0);
                    emit_beat(fu | (hdr_byte & TYPE_MASK), 1'b0, 1'b0);
                end
                fill     = fill + 11'd1;
                frag_end = last || (fill >= mp - 11'd2);
                emit_beat(nb.nalu_byte, 1'b0, frag_end);
                if (frag_end)
                begin
                    seq_num = seq_num + 16'd1;
                    fill    = '0;
                end
            end
            pos = last ? 24'd0 : pos + 24'd1;
        end
        if (pos == 0)
            in_frag = 1'b0;
        if (run_len > 0)
        begin
            t          = rtp_expect.pop_back();
            t.run_last = 1'b1;
            rtp_expect.push_back(t);
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    task automatic push_byte(input logic [23:0] len, input logic [31:0] ts,
                             input logic [7:0] data);
        nalu_beat_t nb;
        nb.nalu_byte   = data;
        nb.nalu_length = len;
        nb.time_stamp  = ts;
        nalu_pending.push_back(nb);
    endtask

    // Continuation bytes carry random length and timestamp; the block ignores them.
    task automatic push_tail_byte();
        push_byte(24'($urandom), $urandom, 8'($urandom));
    endtask

    // Queue `count` bytes of a NALU whose first byte claims `len`.
    task automatic add_nalu(input logic [23:0] len, input int count,
                            input logic [7:0] head, input logic [31:0] ts);
        push_byte(len, ts, head);
        for (int i = 1; i < count; i++)
            push_tail_byte();
    endtask

    // Well-formed random NALUs; a phase may stop in the middle of one.
    task automatic add_stream(input int n);
        int mpe;
        int len;
        int r;
        mpe = (maxpay_reg < MAXPAY_FLOOR) ? int'(MAXPAY_FLOOR) : int'(maxpay_reg);
        repeat (n)
        begin
            if (gen_left == 0)
            begin
                r = $urandom_range(0, 99);
                if (r < 8)
                    len = $urandom_range(0, 1);
                else if (r < 25 && mpe <= 64)
                    len = mpe - 1 + $urandom_range(0, 3);   // straddle the threshold
                else
                    len = $urandom_range(2, 70);
                push_byte(24'(len), $urandom, 8'($urandom));
                gen_left = (len == 0) ? 0 : len - 1;
            end
            else
            begin
                push_tail_byte();
                gen_left--;
            end
        end
    endtask

    task automatic finish_nalu();
        while (gen_left > 0)
        begin
            push_tail_byte();
            gen_left--;
        end
    endtask

    // Wait until every byte is in and every predicted beat is out, then idle.
    task automatic settle();
        @(negedge clk);
        while (nalu_pending.size() != 0 || nalu_valid || rtp_expect.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [31:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            REG_SSRC_ID:      ssrc_reg   = value;
            REG_PAYLOAD_TYPE: pt_reg     = value[6:0];
            REG_MAX_PAYLOAD:  maxpay_reg = value[10:0];
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_config(input logic [31:0] ssrc, input logic [31:0] pt,
                              input logic [31:0] mp);
        cfg_write(REG_SSRC_ID, ssrc);
        cfg_write(REG_PAYLOAD_TYPE, pt);
        cfg_write(REG_MAX_PAYLOAD, mp);
    endtask

    // ------------------------------------------------------------------------
    // Driver: hold a beat until accepted, then advance or idle at random
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nalu_valid <= 1'b0;
            nalu_beat  <= '0;
        end
        else
        begin
            if (nalu_valid && nalu_ready)
                packetize(nalu_beat);
            if (!nalu_valid || nalu_ready)
            begin
                if (nalu_pending.size() != 0 && (steady || $urandom_range(0, 99) >= 16))
                begin
                    nalu_beat  <= nalu_pending.pop_front();
                    nalu_valid <= 1'b1;
                end
                else
                begin
                    nalu_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: check each RTP beat, drive ready with random stalls and one
    // long hold-off that lets the block fill up and stall its input
    // ------------------------------------------------------------------------
    function automatic void check_field(input string what, input logic [7:0] exp_v,
                                        input logic [7:0] got);
        if (got !== exp_v)
        begin
            $display("%0t tb: %s mismatch, expected %0h actual %0h",
                     $time, what, exp_v, got);
            errors++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rtp_ready <= 1'b0;
        end
        else
        begin
            if (rtp_valid && rtp_ready)
            begin
                beats_seen <= beats_seen + 1;
                if (rtp_expect.size() == 0)
                begin
                    $display("%0t tb: unexpected rtp beat, expected none actual %0h",
                             $time, rtp_beat);
                    errors++;
                end
                else
                begin
                    want = rtp_expect.pop_front();
                    check_field("out_byte", want.out_byte, rtp_beat.out_byte);
                    check_field("packet_start", 8'(want.packet_start),
                                8'(rtp_beat.packet_start));
                    check_field("packet_end", 8'(want.packet_end),
                                8'(rtp_beat.packet_end));
                    check_field("run_last", 8'(want.run_last), 8'(rtp_beat.run_last));
                end
            end
            if (hold_left != 0)
            begin
                hold_left <= hold_left - 1;
                rtp_ready <= 1'b0;
            end
            else if (!held_off && beats_seen >= HOLD_AT_BEAT
                     && nalu_pending.size() > HOLD_MIN_PEND)
            begin
                held_off  <= 1'b1;
                hold_left <= HOLD_CYCLES;
                rtp_ready <= 1'b0;
            end
            else
            begin
                rtp_ready <= steady || ($urandom_range(0, 99) >= 16);
            end
        end
    end

    // Watchdog: end the run if neither side moves a beat for too long
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idle_cycles <= 0;
        else if ((nalu_valid && nalu_ready) || (rtp_valid && rtp_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("tb: done, errors");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset settings: zero length taken as one, a one-byte NALU, a short NALU.
        add_nalu(24'd0, 1, 8'hFF, 32'hFFFF_FFFF);
        add_nalu(24'd1, 1, 8'h00, 32'h0000_0000);
        add_nalu(24'd3, 3, 8'h65, $urandom);
        settle();

        // max_payload below the floor acts as 16; 17 bytes give a start and an end fragment.
        set_config(32'hFFFF_FFFF, 32'h0000_007F, 32'd5);
        @(negedge clk);
        add_nalu(24'd17, 17, 8'hFF, $urandom);
        settle();

        // Random phases; boundaries land mid NALU, so registers change mid NALU too.
        set_config(32'h0, 32'h0, 32'd16);
        @(negedge clk);
        add_stream(70);
        settle();

        set_config($urandom, $urandom, 32'd0);
        @(negedge clk);
        add_stream(60);
        settle();

        set_config($urandom, $urandom, {21'($urandom), 11'h7FF});
        @(negedge clk);
        add_stream(40);
        settle();

        // A max_payload of 1500: every NALU fits in a single packet.
        set_config($urandom, 32'(PT_RESET), 32'd1500);
        @(negedge clk);
        finish_nalu();
        add_stream(20);
        settle();

        set_config($urandom, $urandom, 32'($urandom_range(17, 40)));
        @(negedge clk);
        add_stream(80);
        settle();

        // No idling on either side for a whole phase.
        set_config(SSRC_RESET, 32'(PT_RESET), 32'd18);
        @(negedge clk);
        steady = 1'b1;
        add_stream(70);
        finish_nalu();
        settle();
        steady = 1'b0;

        // Close on a NALU that claims the largest length and is cut short.
        set_config($urandom, $urandom, 32'd16);
        @(negedge clk);
        add_stream(30);
        finish_nalu();
        add_nalu(24'hFF_FFFF, 40, 8'($urandom), $urandom);
        settle();

        if (errors == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/h264fua_pkg.sv
hw/rtl/h264fua_front.sv
hw/rtl/h264fua_queue.sv
hw/rtl/h264fua_back.sv
hw/rtl/h264_rtp_fua_packetizer_top.sv
sim/tb.sv
